// ===== rtl/core/beg_pkg.sv =====
// ----------------------------------------------------------------------------
// beg_pkg: shared types for the binary extended GCD block
// Holds the transfer payloads, the sequencer states, the datapath operation
// codes and the status flags that the datapath reports to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package beg_pkg;

  localparam int DATA_BITS = 64;
  localparam int GCD_BITS  = 63;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] a;
    logic signed [DATA_BITS-1:0] b;
  } in_t;

  typedef struct packed {
    logic        [GCD_BITS-1:0]  gcd;
    logic signed [DATA_BITS-1:0] coef_a;
    logic signed [DATA_BITS-1:0] coef_b;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_STRIP,
    S_AHALF,
    S_LOOP,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_ZERO_A,
    OP_ZERO_B,
    OP_STRIP,
    OP_INIT,
    OP_HALVE_A,
    OP_HALVE_B,
    OP_SWAP_SUB,
    OP_SUB
  } op_t;

  typedef struct packed {
    logic am_zero;
    logic bm_zero;
    logic both_even;
    logic am_even;
    logic bm_even;
    logic equal;
    logic bm_lt;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_extended_gcd.sv =====
// ----------------------------------------------------------------------------
// binary_extended_gcd: signed extended GCD by the binary method
// Returns gcd(|a|, |b|) and Bezout coefficients with gcd = coef_a*a + coef_b*b.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one operand pair per
//   transfer. in_stall is high from the cycle after a transfer until the
//   result has been moved into the output register, so one pair is worked
//   on at a time.
//   Output channel out_valid / out_stall / out_data carries one result per
//   input transfer, in order.
//   A zero operand goes from the zero check straight to the result; otherwise
//   the sequencer removes the common twos, halves both values and subtracts,
//   issuing one halve or subtract step per cycle to the shared datapath.
//   A new pair is taken in the cycle after the result enters the output
//   register, even while that result still waits to be taken.
//   Reset clears the sequencer and the output valid flag; the working
//   registers need no reset.
//   When the receiver stalls, the result holds in the output register; a
//   finished next result waits in the datapath until the register frees.
//   Bits of a and b above WORD_BITS are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_extended_gcd #(
  parameter int WORD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  beg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output beg_pkg::out_t out_data
);

  beg_pkg::stat_t status;
  beg_pkg::op_t   op;
  beg_pkg::out_t  result;
  logic           load_out;
  logic           out_free;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid || !out_stall;

  beg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .out_free (out_free),
    .in_stall (in_stall),
    .op       (op),
    .load_out (load_out)
  );

  beg_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .in_data (in_data),
    .op      (op),
    .status  (status),
    .result  (result)
  );

  // output register: load on result, drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= result;
    end
  end

  // never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  // an accepted pair blocks further input until its result is loaded
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a pair is in progress");

  // a load always shows up as a valid result
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("loaded result not presented");

  // no load while idle and waiting for input
  assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !load_out)
    else $error("result loaded with no pair in progress");

endmodule

`default_nettype wire

// ===== rtl/core/beg_ctrl.sv =====
// ----------------------------------------------------------------------------
// beg_ctrl: sequencer for the binary extended GCD block
// Steps the shared datapath through load, zero checks, common-two removal,
// halving of the first value and the subtract/halve loop, one op per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module beg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  beg_pkg::stat_t status,
  input  logic           out_free,
  output logic           in_stall,
  output beg_pkg::op_t   op,
  output logic           load_out
);

  beg_pkg::state_t state;
  beg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= beg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != beg_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    op         = beg_pkg::OP_HOLD;
    load_out   = 1'b0;
    unique case (state)
      beg_pkg::S_IDLE: begin
        if (in_valid) begin
          op         = beg_pkg::OP_LOAD;
          state_next = beg_pkg::S_CHECK;
        end
      end
      beg_pkg::S_CHECK: begin
        priority if (status.am_zero) begin
          op         = beg_pkg::OP_ZERO_A;
          state_next = beg_pkg::S_DONE;
        end else if (status.bm_zero) begin
          op         = beg_pkg::OP_ZERO_B;
          state_next = beg_pkg::S_DONE;
        end else begin
          state_next = beg_pkg::S_STRIP;
        end
      end
      beg_pkg::S_STRIP: begin
        if (status.both_even) begin
          op = beg_pkg::OP_STRIP;
        end else begin
          op         = beg_pkg::OP_INIT;
          state_next = beg_pkg::S_AHALF;
        end
      end
      beg_pkg::S_AHALF: begin
        if (status.am_even) begin
          op = beg_pkg::OP_HALVE_A;
        end else begin
          state_next = beg_pkg::S_LOOP;
        end
      end
      beg_pkg::S_LOOP: begin
        priority if (status.equal) begin
          state_next = beg_pkg::S_DONE;
        end else if (status.bm_even) begin
          op = beg_pkg::OP_HALVE_B;
        end else if (status.bm_lt) begin
          op = beg_pkg::OP_SWAP_SUB;
        end else begin
          op = beg_pkg::OP_SUB;
        end
      end
      beg_pkg::S_DONE: begin
        // hold the result until the output register is free
        if (out_free) begin
          load_out   = 1'b1;
          state_next = beg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = beg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/beg_dp.sv =====
// ----------------------------------------------------------------------------
// beg_dp: working registers and shared arithmetic of the binary extended GCD
// One magnitude subtractor pair and one adder per coefficient lane, reused
// for halving and subtracting under the op code from the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module beg_dp #(
  parameter int WORD_BITS = 64
) (
  input  logic           clk,
  input  beg_pkg::in_t   in_data,
  input  beg_pkg::op_t   op,
  output beg_pkg::stat_t status,
  output beg_pkg::out_t  result
);

  localparam int MW = WORD_BITS - 1;           // magnitude width
  localparam int CW = WORD_BITS + 3;           // coefficient width, with headroom
  localparam int RW = $clog2(WORD_BITS);       // common-two count width
  localparam logic [WORD_BITS-1:0] TOP = {1'b1, {MW{1'b0}}};

  logic [MW-1:0]        am;
  logic [MW-1:0]        bm;
  logic [MW-1:0]        alpha;
  logic [MW-1:0]        beta;
  logic [RW-1:0]        r;
  logic                 aneg;
  logic                 bneg;
  logic signed [CW-1:0] u;
  logic signed [CW-1:0] v;
  logic signed [CW-1:0] s;
  logic signed [CW-1:0] t;

  // Saturated magnitude of the low WORD_BITS bits.
  function automatic logic [MW-1:0] mag(input logic [beg_pkg::DATA_BITS-1:0] raw);
    logic [WORD_BITS-1:0] w;
    logic [WORD_BITS-1:0] n;
    w = raw[WORD_BITS-1:0];
    n = -w;
    if (!w[WORD_BITS-1]) begin
      mag = w[MW-1:0];
    end else if (w == TOP) begin
      mag = '1;
    end else begin
      mag = n[MW-1:0];
    end
  endfunction

  // magnitude compare and subtract
  logic [MW:0]   sub_ba;
  logic [MW-1:0] diff_ab;

  assign sub_ba  = {1'b0, bm} - {1'b0, am};
  assign diff_ab = am - bm;

  assign status.am_zero   = (am == '0);
  assign status.bm_zero   = (bm == '0);
  assign status.both_even = !(am[0] | bm[0]);
  assign status.am_even   = !am[0];
  assign status.bm_even   = !bm[0];
  assign status.equal     = (sub_ba == '0);
  assign status.bm_lt     = sub_ba[MW];

  // coefficient lanes: sum = base +/- oper
  logic signed [CW-1:0] p_base;
  logic signed [CW-1:0] p_oper;
  logic                 p_sub;
  logic signed [CW-1:0] q_base;
  logic signed [CW-1:0] q_oper;
  logic                 q_sub;
  logic                 pair_odd;
  logic signed [CW-1:0] p_sum;
  logic signed [CW-1:0] q_sum;
  logic signed [CW-1:0] p_half;
  logic signed [CW-1:0] q_half;
  logic signed [CW-1:0] beta_ext;
  logic signed [CW-1:0] alpha_ext;

  assign beta_ext  = CW'(beta);
  assign alpha_ext = CW'(alpha);

  always_comb begin
    p_base   = u;
    q_base   = v;
    p_oper   = '0;
    q_oper   = '0;
    p_sub    = 1'b0;
    q_sub    = 1'b0;
    pair_odd = 1'b0;
    unique case (op)
      beg_pkg::OP_HALVE_A: begin
        pair_odd = u[0] | v[0];
        p_base   = u;
        q_base   = v;
        p_oper   = pair_odd ? beta_ext : '0;
        q_oper   = pair_odd ? alpha_ext : '0;
        q_sub    = 1'b1;
      end
      beg_pkg::OP_HALVE_B: begin
        pair_odd = s[0] | t[0];
        p_base   = s;
        q_base   = t;
        p_oper   = pair_odd ? beta_ext : '0;
        q_oper   = pair_odd ? alpha_ext : '0;
        q_sub    = 1'b1;
      end
      beg_pkg::OP_SWAP_SUB: begin
        p_base = u;
        p_oper = s;
        p_sub  = 1'b1;
        q_base = v;
        q_oper = t;
        q_sub  = 1'b1;
      end
      beg_pkg::OP_SUB: begin
        p_base = s;
        p_oper = u;
        p_sub  = 1'b1;
        q_base = t;
        q_oper = v;
        q_sub  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign p_sum  = p_base + (p_sub ? ~p_oper : p_oper) + CW'(p_sub);
  assign q_sum  = q_base + (q_sub ? ~q_oper : q_oper) + CW'(q_sub);
  assign p_half = p_sum >>> 1;
  assign q_half = q_sum >>> 1;

  always_ff @(posedge clk) begin
    unique case (op)
      beg_pkg::OP_LOAD: begin
        am   <= mag(in_data.a);
        bm   <= mag(in_data.b);
        aneg <= in_data.a[WORD_BITS-1];
        bneg <= in_data.b[WORD_BITS-1];
        r    <= '0;
      end
      beg_pkg::OP_ZERO_A: begin
        am <= bm;
        s  <= CW'(0);
        t  <= CW'(1);
      end
      beg_pkg::OP_ZERO_B: begin
        s <= CW'(1);
        t <= CW'(0);
      end
      beg_pkg::OP_STRIP: begin
        am <= am >> 1;
        bm <= bm >> 1;
        r  <= r + RW'(1);
      end
      beg_pkg::OP_INIT: begin
        alpha <= am;
        beta  <= bm;
        u     <= CW'(1);
        v     <= CW'(0);
        s     <= CW'(0);
        t     <= CW'(1);
      end
      beg_pkg::OP_HALVE_A: begin
        am <= am >> 1;
        u  <= p_half;
        v  <= q_half;
      end
      beg_pkg::OP_HALVE_B: begin
        bm <= bm >> 1;
        s  <= p_half;
        t  <= q_half;
      end
      beg_pkg::OP_SWAP_SUB: begin
        am <= bm;
        bm <= diff_ab;
        u  <= s;
        v  <= t;
        s  <= p_sum;
        t  <= q_sum;
      end
      beg_pkg::OP_SUB: begin
        bm <= sub_ba[MW-1:0];
        s  <= p_sum;
        t  <= q_sum;
      end
      default: begin
      end
    endcase
  end

  // final shift and sign fix
  logic [MW-1:0]                 g_shift;
  logic [beg_pkg::DATA_BITS-1:0] x_ext;
  logic [beg_pkg::DATA_BITS-1:0] y_ext;

  assign g_shift = am << r;
  assign x_ext   = beg_pkg::DATA_BITS'(s);
  assign y_ext   = beg_pkg::DATA_BITS'(t);

  assign result.gcd    = beg_pkg::GCD_BITS'(g_shift);
  assign result.coef_a = aneg ? -x_ext : x_ext;
  assign result.coef_b = bneg ? -y_ext : y_ext;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_extended_gcd
// Feeds signed operand pairs through the valid/stall input channel and checks
// every result (gcd and both Bezout coefficients) against a bit-exact
// predictor of the binary method, or a pinned row's fixed result. A short list
// of hand-picked pairs comes first, then randomly shaped pairs, with random gaps
// and stalls on both channels and two long receiver hold-offs that back the block up.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [63:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG   = 64'h8000_0000_0000_0000;
  localparam int          RAND_PAIRS = 750;
  localparam int          LONG_HOLD  = 1500;
  // Cycles to keep watching after the last result for stray transfers.
  localparam int          DRAIN_CYCLES = 300;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  beg_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  beg_pkg::out_t out_data;

  // One line of the directed list. Rows with pinned set carry a result that
  // is obvious by inspection; the rest are checked against the predictor.
  typedef struct packed {
    beg_pkg::in_t  pair;
    logic          pinned;
    beg_pkg::out_t want;
  } dir_row_t;

  // Two 128-bit coefficients that are always halved or swapped together.
  typedef struct packed {
    logic [127:0] p;
    logic [127:0] q;
  } coef_pair_t;

  dir_row_t      dir_rows[$];
  beg_pkg::out_t results_due[$];

  bit send_calm;
  bit rcv_calm;
  int fail_count;
  int results_checked;
  int pairs_sent;
  int dir_sent;
  int zero_pairs;
  int neg_pairs;
  int min_pairs;

  binary_extended_gcd u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL binary_extended_gcd");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Split a word into sign and magnitude; the most negative word saturates
  // to the largest positive magnitude but keeps its negative sign.
  function automatic logic [64:0] sign_mag(logic [63:0] v);
    if (!v[63]) return {1'b0, v};
    if (v == MIN_NEG) return {1'b1, MAX_POS};
    return {1'b1, -v};
  endfunction

  function automatic int low_zeros(logic [63:0] x);
    int n;
    n = 0;
    if (x == '0) return 64;
    while (!x[0]) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  // Halve a coefficient pair; an odd pair first gets (beta, -alpha) added so
  // that the halving stays exact.
  function automatic coef_pair_t halve_coef(coef_pair_t c, logic [63:0] alpha,
                                            logic [63:0] beta);
    if (c.p[0] | c.q[0]) begin
      c.p = c.p + {64'd0, beta};
      c.q = c.q - {64'd0, alpha};
    end
    c.p = {c.p[127], c.p[127:1]};
    c.q = {c.q[127], c.q[127:1]};
    return c;
  endfunction

  function automatic beg_pkg::out_t ext_gcd(beg_pkg::in_t pair);
    logic [64:0]   sa;
    logic [64:0]   sb;
    logic [63:0]   am;
    logic [63:0]   bm;
    logic [63:0]   alpha;
    logic [63:0]   beta;
    logic [63:0]   g;
    logic [63:0]   x;
    logic [63:0]   y;
    int            twos;
    int            az;
    coef_pair_t    uv;
    coef_pair_t    st;
    coef_pair_t    spare;
    beg_pkg::out_t res;
    sa = sign_mag(pair.a);
    sb = sign_mag(pair.b);
    am = sa[63:0];
    bm = sb[63:0];
    if (am == '0) begin
      g = bm;
      x = 64'd0;
      y = 64'd1;
    end else if (bm == '0) begin
      g = am;
      x = 64'd1;
      y = 64'd0;
    end else begin
      // Strip the common twos, then keep (u,v) and (s,t) in step with am, bm.
      twos  = low_zeros(am | bm);
      am    = am >> twos;
      bm    = bm >> twos;
      alpha = am;
      beta  = bm;
      uv.p  = 128'd1;
      uv.q  = 128'd0;
      st.p  = 128'd0;
      st.q  = 128'd1;
      az    = low_zeros(am);
      am    = am >> az;
      repeat (az) uv = halve_coef(uv, alpha, beta);
      while (am != bm) begin
        if (!bm[0]) begin
          bm = bm >> 1;
          st = halve_coef(st, alpha, beta);
        end else begin
          if (bm < am) begin
            {am, bm} = {bm, am};
            spare    = st;
            st       = uv;
            uv       = spare;
          end
          bm   = bm - am;
          st.p = st.p - uv.p;
          st.q = st.q - uv.q;
        end
      end
      g = am << twos;
      x = st.p[63:0];
      y = st.q[63:0];
    end
    if (sa[64]) x = -x;
    if (sb[64]) y = -y;
    res.gcd    = g[62:0];
    res.coef_a = x;
    res.coef_b = y;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int draw_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [63:0] flip_sign(logic [63:0] v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [63:0] pick_corner();
    case ($urandom_range(0, 5))
      0:       return 64'd0;
      1:       return MAX_POS;
      2:       return MIN_NEG;
      3:       return 64'd1;
      4:       return -64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mix of shapes: raw words, short words, pairs sharing a large factor
  // (long subtract chains with many twos), corners, tiny values and pairs
  // where one operand divides the other.
  function automatic beg_pkg::in_t draw_pair();
    beg_pkg::in_t p;
    logic [63:0]  g;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        p.a = {$urandom, $urandom};
        p.b = {$urandom, $urandom};
      end
      3, 4: begin
        p.a = flip_sign({$urandom, $urandom} >> $urandom_range(1, 63));
        p.b = flip_sign({$urandom, $urandom} >> $urandom_range(1, 63));
      end
      5, 6: begin
        g   = ({$urandom, $urandom} >> $urandom_range(34, 63)) << $urandom_range(0, 12);
        p.a = flip_sign(g * ({$urandom, $urandom} >> $urandom_range(44, 63)));
        p.b = flip_sign(g * ({$urandom, $urandom} >> $urandom_range(44, 63)));
      end
      7: begin
        p.a = pick_corner();
        p.b = pick_corner();
      end
      8: begin
        p.a = flip_sign(64'($urandom_range(0, 1000)));
        p.b = flip_sign(64'($urandom_range(0, 1000)));
      end
      default: begin
        g   = {$urandom, $urandom} >> $urandom_range(14, 63);
        p.a = flip_sign(g);
        p.b = flip_sign(g * $urandom_range(1, 255));
        if ($urandom_range(0, 1)) {p.a, p.b} = {p.b, p.a};
      end
    endcase
    return p;
  endfunction

  task automatic add_row(logic [63:0] a, logic [63:0] b, logic pinned,
                         logic [62:0] g, logic [63:0] x, logic [63:0] y);
    dir_row_t row;
    row.pair.a      = a;
    row.pair.b      = b;
    row.pinned      = pinned;
    row.want.gcd    = g;
    row.want.coef_a = x;
    row.want.coef_b = y;
    dir_rows.push_back(row);
  endtask

  // Offer one pair starting at a falling edge; hold it until the transfer,
  // then queue its result. Valid stays up across back-to-back pairs.
  task automatic send_pair(beg_pkg::in_t pair, beg_pkg::out_t want);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= pair;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    results_due.push_back(want);
    pairs_sent++;
    if (pair.a == '0 || pair.b == '0) zero_pairs++;
    if (pair.a[63] || pair.b[63]) neg_pairs++;
    if (pair.a == MIN_NEG || pair.b == MIN_NEG) min_pairs++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every output transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    beg_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (results_due.size() == 0) begin
        $error("result with no pending pair: gcd %0d coef_a %0d coef_b %0d",
               out_data.gcd, $signed(out_data.coef_a), $signed(out_data.coef_b));
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data.gcd !== want.gcd) begin
          $error("field gcd: expected %0d, actual %0d", want.gcd, out_data.gcd);
          fail_count++;
        end
        if (out_data.coef_a !== want.coef_a) begin
          $error("field coef_a: expected %0d, actual %0d",
                 $signed(want.coef_a), $signed(out_data.coef_a));
          fail_count++;
        end
        if (out_data.coef_b !== want.coef_b) begin
          $error("field coef_b: expected %0d, actual %0d",
                 $signed(want.coef_b), $signed(out_data.coef_b));
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall before each result, calm stretches, and two long
  // hold-offs so the block fills up and stalls the sender
  // --------------------------------------------------------------------------
  initial begin
    int hold;
    int taken;
    out_stall = 1'b0;
    rcv_calm  = 1'b0;
    taken     = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 40 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
      hold = (taken == 60 || taken == 420) ? LONG_HOLD : draw_wait(rcv_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      // Stall is low here, so the first valid edge is the transfer.
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    beg_pkg::in_t  pair;
    beg_pkg::out_t want;
    rst             = 1'b1;
    in_valid        = 1'b0;
    in_data         = '0;
    send_calm       = 1'b0;
    fail_count      = 0;
    results_checked = 0;
    pairs_sent      = 0;
    dir_sent        = 0;
    zero_pairs      = 0;
    neg_pairs       = 0;
    min_pairs       = 0;

    // Directed list: zero operands with both signs, the extremes, the most
    // negative word (saturated magnitude, negated coefficient), equal
    // magnitudes, powers of two and a long Fibonacci subtract chain.
    add_row(64'd0,    64'd0,    1'b1, 63'd0, 64'd0,  64'd1);
    add_row(64'd0,    64'd1,    1'b1, 63'd1, 64'd0,  64'd1);
    add_row(64'd0,    -64'd5,   1'b1, 63'd5, 64'd0,  -64'd1);
    add_row(64'd7,    64'd0,    1'b1, 63'd7, 64'd1,  64'd0);
    add_row(-64'd7,   64'd0,    1'b1, 63'd7, -64'd1, 64'd0);
    add_row(MAX_POS,  64'd0,    1'b1, MAX_POS[62:0], 64'd1, 64'd0);
    add_row(64'd0,    MIN_NEG,  1'b1, MAX_POS[62:0], 64'd0, -64'd1);
    add_row(MIN_NEG,  64'd0,    1'b1, MAX_POS[62:0], -64'd1, 64'd0);
    add_row(MAX_POS,  MAX_POS,  1'b1, MAX_POS[62:0], 64'd0, 64'd1);
    add_row(MIN_NEG,  MIN_NEG,  1'b1, MAX_POS[62:0], 64'd0, -64'd1);
    add_row(64'd1,    64'd1,    1'b1, 63'd1, 64'd0,  64'd1);
    add_row(-64'd1,   -64'd1,   1'b1, 63'd1, 64'd0,  -64'd1);
    add_row(-64'd6,   -64'd6,   1'b1, 63'd6, 64'd0,  -64'd1);
    add_row(MAX_POS,  -MAX_POS, 1'b0, '0, '0, '0);
    add_row(64'd12,   64'd18,   1'b0, '0, '0, '0);
    add_row(64'd48,   -64'd180, 1'b0, '0, '0, '0);
    add_row(64'h4000_0000_0000_0000, 64'h0000_0100_0000_0000, 1'b0, '0, '0, '0);
    add_row(64'd1,    MAX_POS,  1'b0, '0, '0, '0);
    add_row(MAX_POS,  64'd1,    1'b0, '0, '0, '0);
    add_row(64'd3,    64'h4000_0000_0000_0000, 1'b0, '0, '0, '0);
    add_row(MAX_POS,  MIN_NEG,  1'b0, '0, '0, '0);
    add_row(MIN_NEG,  64'd1,    1'b0, '0, '0, '0);
    add_row(64'hC000_0000_0000_0000, 64'h4000_0000_0000_0003, 1'b0, '0, '0, '0);
    add_row(64'd7540113804746346429, 64'd4660046610375530309, 1'b0, '0, '0, '0);
    add_row(64'h7FFF_FFFF_FFFF_FFE7, -64'h7FFF_FFFF_FFFF_FF5B, 1'b0, '0, '0, '0);

    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      want = dir_rows[i].pinned ? dir_rows[i].want : ext_gcd(dir_rows[i].pair);
      send_pair(dir_rows[i].pair, want);
      dir_sent++;
    end

    for (int i = 0; i < RAND_PAIRS; i++) begin
      if (i % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
      pair = draw_pair();
      send_pair(pair, ext_gcd(pair));
    end
    in_valid <= 1'b0;

    // Drain: wait for the last result, then watch for stray extra transfers.
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d directed): %0d with a zero operand,",
             pairs_sent, dir_sent, zero_pairs);
    $display("%0d with a negative operand, %0d with the most negative word;",
             neg_pairs, min_pairs);
    $display("%0d results compared.", results_checked);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("PASS binary_extended_gcd");
    end else begin
      $display("FAIL binary_extended_gcd");
    end
    $finish;
  end

endmodule

// ===== binary_extended_gcd.f =====
rtl/core/beg_pkg.sv
rtl/core/beg_ctrl.sv
rtl/core/beg_dp.sv
rtl/core/binary_extended_gcd.sv
test/tb.sv
